@@ sv/sac_pkg.sv @@
package sac_pkg;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int SEQ_LEN   = 5;
	localparam int RESET_LEN = 4;
	localparam int IDX_W     = 3;

	localparam logic [1:0] SCHEME_DEFAULT = 2'd0;
	localparam logic [1:0] SCHEME_NANO    = 2'd1;
	localparam logic [1:0] SCHEME_VIM     = 2'd2;

	localparam logic [7:0] CH_ESC   = 8'h1b;
	localparam logic [7:0] CH_LBR   = 8'h5b;
	localparam logic [7:0] CH_M     = 8'h6d;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_2     = 8'h32;
	localparam logic [7:0] CH_3     = 8'h33;
	localparam logic [7:0] CH_5     = 8'h35;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;

	typedef enum logic [1:0] {
		COL_NONE,
		COL_COMMENT,
		COL_STRING,
		COL_SHEBANG
	} color_t;

	// One command per input byte that produces output. The back end emits, in order:
	// an optional '#', an optional color sequence, c_byte, an optional '!' and an
	// optional reset sequence.
	typedef struct packed {
		logic       a_en;
		color_t     col;
		logic [7:0] c_byte;
		logic       d_en;
		logic       e_en;
	} cmd_t;

	function automatic logic [7:0] color_byte(color_t col, logic [1:0] scheme,
			logic [IDX_W-1:0] idx);
		logic [7:0] d1;
		logic [7:0] d2;
		logic [7:0] b;
		case (col)
			COL_COMMENT: begin
				d1 = (scheme == SCHEME_NANO) ? CH_9 : CH_3;
				d2 = CH_2;
			end
			COL_SHEBANG: begin
				d1 = CH_9;
				d2 = (scheme == SCHEME_VIM) ? CH_5 : CH_1;
			end
			default: begin
				d1 = CH_3;
				d2 = CH_3;
			end
		endcase
		case (idx)
			3'd0:    b = CH_ESC;
			3'd1:    b = CH_LBR;
			3'd2:    b = d1;
			3'd3:    b = d2;
			default: b = CH_M;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] reset_byte(logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0:    b = CH_ESC;
			2'd1:    b = CH_LBR;
			2'd2:    b = CH_0;
			default: b = CH_M;
		endcase
		return b;
	endfunction

endpackage

@@ sv/sac_in_if.sv @@
interface sac_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_script;

	modport source (output valid, output in_byte, output end_of_script, input ready);
	modport sink (input valid, input in_byte, input end_of_script, output ready);
endinterface

@@ sv/sac_out_if.sv @@
interface sac_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_out;

	modport source (output valid, output out_byte, output last_out, input ready);
	modport sink (input valid, input out_byte, input last_out, output ready);
endinterface

@@ sv/sac_front.sv @@
module sac_front (
	input  logic          clk,
	input  logic          arst_n,
	sac_in_if.sink        in_ch,
	input  logic          q_full,
	output logic          q_push,
	output sac_pkg::cmd_t q_data
);
	import sac_pkg::*;

	logic in_comment_q, in_string_q, quote_kind_q, on_first_line_q;
	logic at_start_q, held_hash_q, in_shebang_q;
	logic n_in_comment, n_in_string, n_quote_kind, n_on_first_line;
	logic n_at_start, n_held_hash, n_in_shebang;

	logic [7:0] c;
	logic       eos;
	logic       is_quote;
	logic [7:0] closer;
	logic       use_plain;
	logic       emit;
	logic       accept;
	cmd_t       cmd;

	assign c        = in_ch.in_byte;
	assign eos      = in_ch.end_of_script;
	assign is_quote = (c == CH_DQUOTE) || (c == CH_SQUOTE);
	assign closer   = quote_kind_q ? CH_SQUOTE : CH_DQUOTE;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign q_push      = accept && emit;
	assign q_data      = cmd;

	always_comb begin
		cmd             = '0;
		cmd.col         = COL_NONE;
		cmd.c_byte      = c;
		emit            = 1'b1;
		use_plain       = 1'b0;
		n_in_comment    = in_comment_q;
		n_in_string     = in_string_q;
		n_quote_kind    = quote_kind_q;
		n_on_first_line = on_first_line_q;
		n_at_start      = at_start_q;
		n_held_hash     = held_hash_q;
		n_in_shebang    = in_shebang_q;

		if (in_shebang_q) begin
			if (c == CH_LF || eos) begin
				cmd.e_en        = 1'b1;
				n_in_shebang    = 1'b0;
				n_on_first_line = 1'b0;
			end
		end else if (held_hash_q) begin
			n_held_hash = 1'b0;
			if (c == CH_BANG) begin
				cmd.col      = COL_SHEBANG;
				cmd.c_byte   = CH_HASH;
				cmd.d_en     = 1'b1;
				cmd.e_en     = eos;
				n_in_shebang = !eos;
			end else begin
				// The held '#' sits on the first line, so it goes out as plain text.
				cmd.a_en  = 1'b1;
				use_plain = 1'b1;
			end
		end else if (at_start_q) begin
			n_at_start = 1'b0;
			if (c == CH_HASH && !eos) begin
				n_held_hash = 1'b1;
				emit        = 1'b0;
			end else begin
				use_plain = 1'b1;
			end
		end else begin
			use_plain = 1'b1;
		end

		if (use_plain) begin
			if (!in_string_q && c == CH_HASH && !on_first_line_q) begin
				if (!in_comment_q) begin
					cmd.col = COL_COMMENT;
				end
				n_in_comment = 1'b1;
			end else if (!in_comment_q && !in_string_q && is_quote) begin
				cmd.col      = COL_STRING;
				n_in_string  = 1'b1;
				n_quote_kind = (c == CH_SQUOTE);
			end else if (in_string_q && c == closer) begin
				cmd.e_en    = 1'b1;
				n_in_string = 1'b0;
			end else if (in_comment_q && c == CH_LF) begin
				cmd.e_en        = 1'b1;
				n_in_comment    = 1'b0;
				n_on_first_line = 1'b0;
			end else if (c == CH_LF) begin
				n_on_first_line = 1'b0;
			end
		end

		if (eos) begin
			if (n_in_comment || n_in_string) begin
				cmd.e_en = 1'b1;
			end
			n_in_comment    = 1'b0;
			n_in_string     = 1'b0;
			n_quote_kind    = 1'b0;
			n_on_first_line = 1'b1;
			n_at_start      = 1'b1;
			n_held_hash     = 1'b0;
			n_in_shebang    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_comment_q    <= 1'b0;
			in_string_q     <= 1'b0;
			quote_kind_q    <= 1'b0;
			on_first_line_q <= 1'b1;
			at_start_q      <= 1'b1;
			held_hash_q     <= 1'b0;
			in_shebang_q    <= 1'b0;
		end else if (accept) begin
			in_comment_q    <= n_in_comment;
			in_string_q     <= n_in_string;
			quote_kind_q    <= n_quote_kind;
			on_first_line_q <= n_on_first_line;
			at_start_q      <= n_at_start;
			held_hash_q     <= n_held_hash;
			in_shebang_q    <= n_in_shebang;
		end
	end

	a_hold_clean: assert property (@(posedge clk) disable iff (!arst_n)
		held_hash_q |-> (on_first_line_q && !in_comment_q && !in_string_q && !at_start_q))
		else $error("held hash outside the start of a script");

	a_shebang_clean: assert property (@(posedge clk) disable iff (!arst_n)
		in_shebang_q |-> (!held_hash_q && !in_comment_q && !in_string_q && on_first_line_q))
		else $error("shebang line overlaps another mode");

	a_modes_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_comment_q && in_string_q))
		else $error("comment and string open at once");

	a_hold_emits_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && at_start_q && !in_shebang_q && !held_hash_q && c == CH_HASH && !eos)
		|-> !q_push)
		else $error("held hash produced output");

endmodule

@@ sv/sac_fifo.sv @@
module sac_fifo #(
	parameter int DEPTH = sac_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sac_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output sac_pkg::cmd_t pop_data,
	output logic          not_empty
);
	import sac_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into a full queue");

	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count missed a push");

endmodule

@@ sv/sac_back.sv @@
module sac_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    scheme,
	input  logic          q_valid,
	input  sac_pkg::cmd_t q_data,
	output logic          q_pop,
	sac_out_if.source     out_ch
);
	import sac_pkg::*;

	typedef enum logic [2:0] {
		PH_A,
		PH_B,
		PH_C,
		PH_D,
		PH_E
	} phase_t;

	logic             valid_q;
	cmd_t             cmd_q;
	phase_t           phase_q;
	logic [IDX_W-1:0] idx_q;

	logic   phase_end;
	logic   more;
	phase_t next_phase;
	phase_t first_phase;
	logic   fire;
	logic   load;

	always_comb begin
		case (phase_q)
			PH_A:    out_ch.out_byte = CH_HASH;
			PH_B:    out_ch.out_byte = color_byte(cmd_q.col, scheme, idx_q);
			PH_C:    out_ch.out_byte = cmd_q.c_byte;
			PH_D:    out_ch.out_byte = CH_BANG;
			default: out_ch.out_byte = reset_byte(idx_q[1:0]);
		endcase
	end

	always_comb begin
		phase_end  = 1'b1;
		more       = 1'b0;
		next_phase = PH_C;
		case (phase_q)
			PH_A: begin
				more       = 1'b1;
				next_phase = (cmd_q.col != COL_NONE) ? PH_B : PH_C;
			end
			PH_B: begin
				phase_end  = (idx_q == IDX_W'(SEQ_LEN - 1));
				more       = 1'b1;
				next_phase = PH_C;
			end
			PH_C: begin
				more       = cmd_q.d_en || cmd_q.e_en;
				next_phase = cmd_q.d_en ? PH_D : PH_E;
			end
			PH_D: begin
				more       = cmd_q.e_en;
				next_phase = PH_E;
			end
			default: begin
				phase_end = (idx_q == IDX_W'(RESET_LEN - 1));
				more      = 1'b0;
			end
		endcase
	end

	always_comb begin
		if (q_data.a_en) begin
			first_phase = PH_A;
		end else if (q_data.col != COL_NONE) begin
			first_phase = PH_B;
		end else begin
			first_phase = PH_C;
		end
	end

	assign out_ch.valid    = valid_q;
	assign out_ch.last_out = phase_end && !more;
	assign fire            = valid_q && out_ch.ready;
	// The next command loads in the cycle its predecessor's last byte leaves.
	assign load            = !valid_q || (fire && out_ch.last_out);
	assign q_pop           = load && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= PH_C;
			idx_q   <= '0;
			cmd_q   <= '0;
		end else if (load) begin
			valid_q <= q_valid;
			if (q_valid) begin
				cmd_q   <= q_data;
				phase_q <= first_phase;
				idx_q   <= '0;
			end
		end else if (fire) begin
			if (phase_end) begin
				phase_q <= next_phase;
				idx_q   <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	a_seq_has_color: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && phase_q == PH_B) |-> (cmd_q.col != COL_NONE))
		else $error("color phase without a color");

	a_bang_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && phase_q == PH_D) |-> cmd_q.d_en)
		else $error("bang phase not requested");

	a_reset_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && phase_q == PH_E) |-> cmd_q.e_en)
		else $error("reset phase not requested");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> ((phase_q == PH_B && idx_q < IDX_W'(SEQ_LEN)) ||
			(phase_q == PH_E && idx_q < IDX_W'(RESET_LEN)) ||
			(phase_q != PH_B && phase_q != PH_E && idx_q == '0)))
		else $error("sequence index out of range");

endmodule

@@ sv/shell_script_ansi_colorizer.sv @@
// Shell-script colorizer: script bytes enter on in_ch, one transaction per byte, and leave on
// out_ch with ANSI color sequences put round a leading shebang line, comments and quoted
// strings; last_out marks the final output byte caused by each input byte. The input side
// takes one byte per cycle while the small command queue has room. The output side sends one
// byte per cycle while out_ch.ready is high, and an input byte gives 1 to 11 output bytes (1
// for plain text, 5 more for a color, 4 more for a reset, 1 more for a '#' or a '!'); sustained
// rate is one input byte per cycle for plain text while out_ch.ready is high and is set by the
// output sequencer. A first byte '#' is held with no output until the next byte shows whether it
// starts a shebang. An input's first output byte passes through the command queue and the
// sequencer's command register before it can be taken. color_scheme is written through cfg_we
// and cfg_wdata (0 default, 1 nano, 2 vim, 3 acts as default) and must only change while idle.
module shell_script_ansi_colorizer #(
	parameter int QUEUE_DEPTH = sac_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	sac_in_if.sink     in_ch,
	sac_out_if.source  out_ch,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata
);
	import sac_pkg::*;

	logic [1:0] color_scheme_q;
	logic       q_full;
	logic       q_push;
	cmd_t       q_wdata;
	logic       q_pop;
	cmd_t       q_rdata;
	logic       q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_scheme_q <= SCHEME_DEFAULT;
		end else if (cfg_we) begin
			color_scheme_q <= cfg_wdata;
		end
	end

	sac_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_wdata)
	);

	sac_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.not_empty (q_valid)
	);

	sac_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.scheme  (color_scheme_q),
		.q_valid (q_valid),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.out_ch  (out_ch)
	);

endmodule
